// ===== sv/masked_byte_pattern_search_unit_macros.svh =====
// Assertion macros for the masked byte pattern search unit.
`ifndef MASKED_BYTE_PATTERN_SEARCH_UNIT_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define MBPS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mbps: assertion failed");
`define MBPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbps: implication failed");
`else
`define MBPS_ASSERT(lbl, clk, rst_n, prop)
`define MBPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/mbps_pkg.sv =====
package mbps_pkg;

    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 64;
    localparam int LEN_W   = 9;
    localparam int IDX_W   = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_PATTERN_LENGTH = 1'b0;

    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_SCAN = 1'b1
    } t_req;

    typedef enum logic {
        ST_IDLE,
        ST_REPLAY
    } t_state;

    typedef struct packed {
        logic shift;
        logic replay;
        logic flush;
    } t_row_ctl;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] value;
        logic              care;
    } t_pat_wr;

endpackage

// ===== sv/mbps_cell.sv =====
module mbps_cell
    import mbps_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  t_pat_wr           i_wr,
    input  logic [BYTE_W-1:0] i_feed,
    input  logic [BYTE_W-1:0] i_win,
    input  logic              i_link,
    output logic [BYTE_W-1:0] o_win,
    output logic              o_d,
    output logic              o_d_next
);

    logic [BYTE_W-1:0] r_win;
    logic [BYTE_W-1:0] r_pat;
    logic              r_care;
    logic              r_d;
    logic              n_d;
    logic              hit;

    assign hit = !r_care || (i_feed == r_pat);
    assign n_d = i_link && hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d <= 1'b0;
        end else if (i_shift) begin
            r_d <= n_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_win <= i_win;
        end
        if (i_wr.we && (32'(i_wr.idx) == INDEX)) begin
            r_pat  <= i_wr.value;
            r_care <= i_wr.care;
        end
    end

    assign o_win    = r_win;
    assign o_d      = r_d;
    assign o_d_next = n_d;

endmodule

// ===== sv/mbps_row.sv =====
module mbps_row
    import mbps_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_row_ctl          i_ctl,
    input  t_pat_wr           i_wr,
    input  logic [BYTE_W-1:0] i_data,
    output logic [DEPTH-1:0]  o_d_next
);

    logic [BYTE_W-1:0] win    [DEPTH];
    logic [BYTE_W-1:0] win_in [DEPTH];
    logic [DEPTH-1:0]  d;
    logic [DEPTH-1:0]  link;
    logic [BYTE_W-1:0] feed;

    // replay rotates the window, oldest byte first
    assign feed = i_ctl.replay ? win[DEPTH-1] : i_data;

    always_comb begin
        link[0]   = 1'b1;
        win_in[0] = feed;
        for (int k = 1; k < DEPTH; k++) begin
            link[k]   = d[k-1] && !i_ctl.flush;
            win_in[k] = win[k-1];
        end
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        mbps_cell #(
            .INDEX (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_shift  (i_ctl.shift),
            .i_wr     (i_wr),
            .i_feed   (feed),
            .i_win    (win_in[k]),
            .i_link   (link[k]),
            .o_win    (win[k]),
            .o_d      (d[k]),
            .o_d_next (o_d_next[k])
        );
    end

endmodule

// ===== sv/masked_byte_pattern_search_unit.sv =====
// channel | valid   | stall   | payload
// --------+---------+---------+------------------------------------------------
// in      | i_valid | o_stall | i_req_type, i_pattern_*, i_data_byte, ...
// out     | o_valid | i_stall | o_found, o_match_address, o_status
// config  | APB: psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One item per cycle while o_stall is low; a match or region end is
// flagged on the cycle after the byte that causes it is taken.
// A scan item that follows pattern loads inside a run waits while the
// window rotates once through the cell chain.
// Synchronous reset clears the run, pattern length and output; pattern
// entries hold nothing valid until loaded.
// A stalled result also stalls the input.
`include "masked_byte_pattern_search_unit_macros.svh"

module masked_byte_pattern_search_unit
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic [IDX_W-1:0]   i_pattern_index,
    input  logic [BYTE_W-1:0]  i_pattern_value,
    input  logic               i_pattern_care,
    input  logic [BYTE_W-1:0]  i_data_byte,
    input  logic [ADDR_W-1:0]  i_byte_address,
    input  logic               i_first_byte,
    input  logic               i_last_byte,

    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_found,
    output logic [ADDR_W-1:0]  o_match_address,
    output logic               o_status,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    t_state             r_state, n_state;
    logic [IW-1:0]      r_cnt, n_cnt;
    logic               r_dirty, n_dirty;
    logic [LEN_W-1:0]   r_len;
    logic [CW-1:0]      r_run, n_run;
    logic [ADDR_W-1:0]  r_exp;
    logic               r_done, n_done;
    logic               r_out_valid;
    logic               r_found;
    logic [ADDR_W-1:0]  r_match_addr;
    logic               r_status;

    logic               in_acc;
    logic               scan_acc;
    logic               load_acc;
    logic               hold_for_replay;
    logic               scan_flush;
    logic               replay_flush;
    logic               done_eff;
    logic               hit;
    logic               emit;
    logic [CW-1:0]      len_eff;
    logic [CW-1:0]      len_m1;
    logic [IW-1:0]      sel;
    logic [CW-1:0]      run_base;
    logic [MAX_PATTERN-1:0] d_next;
    t_row_ctl           ctl;
    t_pat_wr            wr;
    logic               cfg_we;

    // ---- handshake ----
    assign hold_for_replay = r_dirty && i_valid && (i_req_type == REQ_SCAN);
    assign o_stall  = (r_state != ST_IDLE) || hold_for_replay || (r_out_valid && i_stall);
    assign in_acc   = i_valid && !o_stall;
    assign scan_acc = in_acc && (i_req_type == REQ_SCAN);
    assign load_acc = in_acc && (i_req_type == REQ_LOAD);

    // ---- cell chain ----
    assign scan_flush   = i_first_byte || (i_byte_address != r_exp);
    assign replay_flush = (32'(r_cnt) + 32'(r_run)) <= MAX_PATTERN;

    always_comb begin
        ctl.replay = (r_state == ST_REPLAY);
        ctl.shift  = scan_acc || ctl.replay;
        ctl.flush  = ctl.replay ? replay_flush : scan_flush;
        wr.we      = load_acc && (32'(i_pattern_index) < MAX_PATTERN);
        wr.idx     = i_pattern_index;
        wr.value   = i_pattern_value;
        wr.care    = i_pattern_care;
    end

    mbps_row #(
        .DEPTH (MAX_PATTERN)
    ) u_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_wr     (wr),
        .i_data   (i_data_byte),
        .o_d_next (d_next)
    );

    // ---- match decision ----
    always_comb begin
        if (32'(r_len) > MAX_PATTERN) begin
            len_eff = CW'(MAX_PATTERN);
        end else begin
            len_eff = CW'(r_len);
        end
        len_m1   = len_eff - CW'(1);
        sel      = len_m1[IW-1:0];
        hit      = (len_eff != '0) && d_next[sel];
        done_eff = i_first_byte ? 1'b0 : r_done;
        emit     = !done_eff && (hit || i_last_byte);
        n_done   = done_eff || emit;
        run_base = scan_flush ? '0 : r_run;
        if (32'(run_base) < MAX_PATTERN) begin
            n_run = run_base + CW'(1);
        end else begin
            n_run = run_base;
        end
    end

    // ---- replay sequencer ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_dirty <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dirty <= n_dirty;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_dirty = r_dirty;
        case (r_state)
            ST_IDLE: begin
                if (hold_for_replay) begin
                    n_state = ST_REPLAY;
                    n_cnt   = '0;
                end
                if (load_acc && (r_run != '0)) begin
                    n_dirty = 1'b1;
                end
            end
            ST_REPLAY: begin
                n_cnt = r_cnt + IW'(1);
                if (32'(r_cnt) == MAX_PATTERN - 1) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                    n_dirty = 1'b0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---- run state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= '0;
            r_exp  <= '0;
            r_done <= 1'b0;
        end else if (scan_acc) begin
            r_run  <= n_run;
            r_exp  <= i_byte_address + ADDR_W'(1);
            r_done <= n_done;
        end
    end

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (scan_acc && emit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_acc && emit) begin
            r_found      <= hit;
            r_match_addr <= hit ? (i_byte_address - ADDR_W'(len_m1)) : '0;
            r_status     <= (!hit && (len_eff == '0)) ? STATUS_EMPTY : STATUS_OK;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_found         = r_found;
    assign o_match_address = r_match_addr;
    assign o_status        = r_status;

    // ---- configuration ----
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_PATTERN_LENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (cfg_we) begin
            r_len <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_PATTERN_LENGTH) ? PDATA_W'(r_len) : '0;
    assign pready = 1'b1;

    // ---- assertions ----
    `MBPS_ASSERT(a_replay_ends, i_clk, i_rst_n,
        (r_state == ST_REPLAY && 32'(r_cnt) == MAX_PATTERN - 1) |=>
        (r_state == ST_IDLE && !r_dirty))
    `MBPS_ASSERT_IMPL(a_no_match_zero_addr, i_clk, i_rst_n,
        o_valid && !o_found, o_match_address == '0)
    `MBPS_ASSERT_IMPL(a_empty_not_found, i_clk, i_rst_n,
        o_valid && (o_status == STATUS_EMPTY), !o_found)
    `MBPS_ASSERT_IMPL(a_run_bounded, i_clk, i_rst_n, 1'b1, 32'(r_run) <= MAX_PATTERN)
    `MBPS_ASSERT(a_result_closes_region, i_clk, i_rst_n,
        (scan_acc && emit) |=> r_done)

endmodule
